@@ sv/mpsl_pkg.sv @@
package mpsl_pkg;

    localparam int NUM_PORTS = 9;
    localparam int PORT_W = 4;
    localparam int ADDR_W = 18;
    localparam int DATA_W = 16;
    localparam int MEM_AW = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
    localparam int ATTACH_W = NUM_PORTS;

    // Operation codes of a request.
    localparam logic [1:0] OP_READ = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_RX = 2'd2;

    // Register offsets within a port's group.
    localparam logic [2:0] OFF_RX_CSR = 3'd0;
    localparam logic [2:0] OFF_RX_BUF = 3'd2;
    localparam logic [2:0] OFF_TX_CSR = 3'd4;
    localparam logic [2:0] OFF_TX_BUF = 3'd6;

    localparam int BIT_IE = 6;
    localparam int BIT_DONE = 7;

    localparam logic [7:0] CON_RX_VEC = 8'o060;
    localparam logic [7:0] CON_TX_VEC = 8'o064;
    localparam logic [7:0] TTY_RX_VEC = 8'o300;
    localparam logic [7:0] TTY_TX_VEC = 8'o304;

    localparam logic [DATA_W-1:0] RX_DATA_RESET = 16'o177;

    // Configuration register indexes.
    localparam logic CFG_CONSOLE_BASE = 1'b0;
    localparam logic CFG_PORT_ATTACHED = 1'b1;

    localparam logic [ADDR_W-1:0] CONSOLE_BASE_RESET = 18'd262000;
    localparam logic [ATTACH_W-1:0] PORT_ATTACHED_RESET = ATTACH_W'(1);

    typedef struct packed {
        logic [1:0]        operation;
        logic [ADDR_W-1:0] bus_address;
        logic [DATA_W-1:0] write_data;
        logic [3:0]        rx_port;
        logic [7:0]        rx_char;
    } req_item_t;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              addr_fault;
        logic              tx_valid;
        logic [3:0]        tx_port;
        logic [6:0]        tx_char;
        logic              rx_taken;
        logic              irq_valid;
        logic [7:0]        irq_vector;
        logic              irq_delayed;
    } rsp_item_t;

    // Register state of one port.
    typedef struct packed {
        logic              rx_done;
        logic              rx_en;
        logic [DATA_W-1:0] rx_data;
        logic              tx_en;
        logic [DATA_W-1:0] tx_data;
    } port_entry_t;

    localparam port_entry_t ENTRY_RESET = '{
        rx_done: 1'b0,
        rx_en: 1'b0,
        rx_data: RX_DATA_RESET,
        tx_en: 1'b0,
        tx_data: '0
    };

    // Port selection decoded from a request.
    typedef struct packed {
        logic [PORT_W-1:0] port;
        logic              port_ok;
        logic              attached;
    } port_ctx_t;

endpackage

@@ sv/mpsl_port_ram.sv @@
module mpsl_port_ram (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     rd_en,
    input  logic [mpsl_pkg::PORT_W-1:0] rd_port,
    output mpsl_pkg::port_entry_t    rd_data,
    input  logic                     wr_en,
    input  logic [mpsl_pkg::PORT_W-1:0] wr_port,
    input  mpsl_pkg::port_entry_t    wr_data
);

    mpsl_pkg::port_entry_t mem [mpsl_pkg::NUM_PORTS];
    mpsl_pkg::port_entry_t rdata_reg;
    logic [mpsl_pkg::NUM_PORTS-1:0] written_reg;
    logic rd_init_reg;

    logic [mpsl_pkg::MEM_AW-1:0] rd_idx;
    logic [mpsl_pkg::MEM_AW-1:0] wr_idx;

    assign rd_idx = rd_port[mpsl_pkg::MEM_AW-1:0];
    assign wr_idx = wr_port[mpsl_pkg::MEM_AW-1:0];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_idx];
        end
    end

    // An entry never written since reset reads as its reset value.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg <= '0;
            rd_init_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                written_reg[wr_idx] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_init_reg <= written_reg[rd_idx];
            end
        end
    end

    assign rd_data = rd_init_reg ? rdata_reg : mpsl_pkg::ENTRY_RESET;

endmodule

@@ sv/mpsl_update.sv @@
module mpsl_update (
    input  mpsl_pkg::req_item_t   item,
    input  mpsl_pkg::port_ctx_t   ctx,
    input  mpsl_pkg::port_entry_t cur,
    output mpsl_pkg::port_entry_t nxt,
    output logic                  wr_en,
    output mpsl_pkg::rsp_item_t   rsp
);

    function automatic logic [7:0] vec_of(
        input logic [mpsl_pkg::PORT_W-1:0] p,
        input logic [7:0] con_vec,
        input logic [7:0] tty_vec
    );
        logic [mpsl_pkg::PORT_W-1:0] pm1;
        begin
            pm1 = p - mpsl_pkg::PORT_W'(1);
            vec_of = (p == '0) ? con_vec
                               : tty_vec + 8'({pm1, 3'b000});
        end
    endfunction

    logic is_bus;
    logic [2:0] off;
    logic ie_bit;

    assign is_bus = (item.operation == mpsl_pkg::OP_READ)
                 || (item.operation == mpsl_pkg::OP_WRITE);
    assign off = item.bus_address[2:0];
    assign ie_bit = item.write_data[mpsl_pkg::BIT_IE];
    assign wr_en = ctx.port_ok;

    always_comb
    begin
        nxt = cur;
        rsp = '0;
        if (is_bus && !ctx.port_ok)
        begin
            rsp.addr_fault = 1'b1;
        end
        else if (ctx.port_ok && item.operation == mpsl_pkg::OP_READ)
        begin
            unique case (off)
                mpsl_pkg::OFF_RX_CSR:
                begin
                    rsp.read_data[mpsl_pkg::BIT_DONE] = cur.rx_done;
                    rsp.read_data[mpsl_pkg::BIT_IE] = cur.rx_en;
                end
                mpsl_pkg::OFF_RX_BUF:
                begin
                    rsp.read_data = cur.rx_data;
                    nxt.rx_done = 1'b0;
                end
                mpsl_pkg::OFF_TX_CSR:
                begin
                    rsp.read_data[mpsl_pkg::BIT_DONE] = 1'b1;
                    rsp.read_data[mpsl_pkg::BIT_IE] = cur.tx_en;
                end
                mpsl_pkg::OFF_TX_BUF:
                begin
                    rsp.read_data = cur.tx_data;
                end
                default:
                begin
                end
            endcase
        end
        else if (ctx.port_ok && item.operation == mpsl_pkg::OP_WRITE)
        begin
            unique case (off)
                mpsl_pkg::OFF_RX_CSR:
                begin
                    if (ie_bit)
                    begin
                        nxt.rx_en = 1'b1;
                    end
                end
                mpsl_pkg::OFF_RX_BUF:
                begin
                    nxt.rx_data = item.write_data;
                    nxt.rx_done = 1'b0;
                end
                mpsl_pkg::OFF_TX_CSR:
                begin
                    // Turning the enable on raises a transmit interrupt request, marked as delayed.
                    if (ie_bit && !cur.tx_en)
                    begin
                        rsp.irq_valid = 1'b1;
                        rsp.irq_vector = vec_of(ctx.port, mpsl_pkg::CON_TX_VEC,
                                                mpsl_pkg::TTY_TX_VEC);
                        rsp.irq_delayed = 1'b1;
                    end
                    if (ie_bit)
                    begin
                        nxt.tx_en = 1'b1;
                    end
                end
                mpsl_pkg::OFF_TX_BUF:
                begin
                    nxt.tx_data = item.write_data;
                    if (ctx.attached)
                    begin
                        rsp.tx_valid = 1'b1;
                        rsp.tx_port = ctx.port;
                        rsp.tx_char = item.write_data[6:0];
                    end
                    if (cur.tx_en)
                    begin
                        rsp.irq_valid = 1'b1;
                        rsp.irq_vector = vec_of(ctx.port, mpsl_pkg::CON_TX_VEC,
                                                mpsl_pkg::TTY_TX_VEC);
                        rsp.irq_delayed = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
        else if (item.operation == mpsl_pkg::OP_RX)
        begin
            if (ctx.attached && !cur.rx_done)
            begin
                nxt.rx_done = 1'b1;
                nxt.rx_data = {9'b0, item.rx_char[6:0]};
                rsp.rx_taken = 1'b1;
                if (cur.rx_en)
                begin
                    rsp.irq_valid = 1'b1;
                    rsp.irq_vector = vec_of(ctx.port, mpsl_pkg::CON_RX_VEC,
                                            mpsl_pkg::TTY_RX_VEC);
                end
            end
        end
    end

endmodule

@@ sv/multi_port_serial_line_registers_unit.sv @@
// Register block for a console serial port and up to eight more ports. Each request
// (bus read, bus write or received character) is answered by exactly one response,
// held in stage one and then in the output register. The per-port registers live
// in a small RAM with a registered read; the entry written back in the cycle a
// following request reads it is forwarded, so back-to-back requests to the same
// port see each other's updates. A new request can be taken every cycle, but a
// stalled response holds the pipeline, and request stall rises only while it does.
module multi_port_serial_line_registers_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            req_valid,
    output logic                            req_stall,
    input  mpsl_pkg::req_item_t             req,
    output logic                            rsp_valid,
    input  logic                            rsp_stall,
    output mpsl_pkg::rsp_item_t             rsp,
    input  logic                            cfg_we,
    input  logic                            cfg_index,
    input  logic [mpsl_pkg::ADDR_W-1:0]     cfg_data
);

    logic [mpsl_pkg::ADDR_W-1:0]   console_base_reg;
    logic [mpsl_pkg::ATTACH_W-1:0] port_attached_reg;

    logic                  s1_valid_reg;
    mpsl_pkg::req_item_t   s1_item_reg;
    mpsl_pkg::port_ctx_t   s1_ctx_reg;
    logic                  fwd_hit_reg;
    mpsl_pkg::port_entry_t fwd_data_reg;
    logic                  out_valid_reg;
    mpsl_pkg::rsp_item_t   out_item_reg;

    logic                  req_accept;
    logic                  s1_fire;
    mpsl_pkg::port_ctx_t   s0_ctx;
    logic                  s0_is_bus;
    logic [mpsl_pkg::PORT_W-1:0]   s0_bus_port;
    logic [mpsl_pkg::ATTACH_W-1:0] attach_shift;
    mpsl_pkg::port_entry_t ram_rdata;
    mpsl_pkg::port_entry_t cur_entry;
    mpsl_pkg::port_entry_t nxt_entry;
    logic                  upd_wr_en;
    logic                  mem_we;
    mpsl_pkg::rsp_item_t   upd_rsp;

    assign s1_fire = s1_valid_reg && (!out_valid_reg || !rsp_stall);
    assign req_stall = s1_valid_reg && !s1_fire;
    assign req_accept = req_valid && !req_stall;

    // Port decode: the console group matches on the address with its low bits cleared.
    assign s0_is_bus = (req.operation == mpsl_pkg::OP_READ)
                    || (req.operation == mpsl_pkg::OP_WRITE);
    assign s0_bus_port = ({req.bus_address[mpsl_pkg::ADDR_W-1:3], 3'b000} == console_base_reg)
                       ? '0
                       : {1'b0, req.bus_address[5:3]} + mpsl_pkg::PORT_W'(1);

    always_comb
    begin
        s0_ctx.port = s0_is_bus ? s0_bus_port : req.rx_port;
        s0_ctx.port_ok = (s0_is_bus || req.operation == mpsl_pkg::OP_RX)
                      && (s0_ctx.port < mpsl_pkg::PORT_W'(mpsl_pkg::NUM_PORTS));
        attach_shift = port_attached_reg >> s0_ctx.port;
        s0_ctx.attached = s0_ctx.port_ok && attach_shift[0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            console_base_reg <= mpsl_pkg::CONSOLE_BASE_RESET;
            port_attached_reg <= mpsl_pkg::PORT_ATTACHED_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == mpsl_pkg::CFG_CONSOLE_BASE)
            begin
                console_base_reg <= cfg_data;
            end
            else if (cfg_index == mpsl_pkg::CFG_PORT_ATTACHED)
            begin
                port_attached_reg <= cfg_data[mpsl_pkg::ATTACH_W-1:0];
            end
        end
    end

    mpsl_port_ram u_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (req_accept && s0_ctx.port_ok),
        .rd_port (s0_ctx.port),
        .rd_data (ram_rdata),
        .wr_en   (mem_we),
        .wr_port (s1_ctx_reg.port),
        .wr_data (nxt_entry)
    );

    assign cur_entry = fwd_hit_reg ? fwd_data_reg : ram_rdata;

    mpsl_update u_update (
        .item  (s1_item_reg),
        .ctx   (s1_ctx_reg),
        .cur   (cur_entry),
        .nxt   (nxt_entry),
        .wr_en (upd_wr_en),
        .rsp   (upd_rsp)
    );

    assign mem_we = s1_fire && upd_wr_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            fwd_hit_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (req_accept)
            begin
                s1_valid_reg <= 1'b1;
                fwd_hit_reg <= mem_we && (s1_ctx_reg.port == s0_ctx.port);
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // The entry being written as the next request reads its port is captured here.
    always_ff @(posedge clk)
    begin
        if (req_accept)
        begin
            s1_item_reg <= req;
            s1_ctx_reg <= s0_ctx;
            fwd_data_reg <= nxt_entry;
        end
        if (s1_fire)
        begin
            out_item_reg <= upd_rsp;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp = out_item_reg;

    a_err_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.addr_fault |-> !rsp.irq_valid && !rsp.tx_valid && !rsp.rx_taken)
        else $error("address fault response also reports activity");

    a_tx_port_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.tx_valid
            |-> rsp.tx_port < mpsl_pkg::PORT_W'(mpsl_pkg::NUM_PORTS))
        else $error("transmit on a port that does not exist");

    a_delayed_needs_irq: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.irq_delayed |-> rsp.irq_valid)
        else $error("delayed flag without interrupt request");

    a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_fire |=> s1_valid_reg && $stable(s1_ctx_reg))
        else $error("stage one lost or changed its request while held");

endmodule
